FILE: hdl/fbpa_pkg.sv
// Package for the fixed block pool allocator.
// Holds request codes, status codes, controller states and fixed field widths.
// No dependencies.
package fbpa_pkg;

    // Field widths that the interface fixes.
    localparam int COUNT_W = 9;
    localparam int BSIZE_W = 17;

    // Block size after reset.
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd4;

    // Request codes. The fourth code is a no-op request.
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NULL  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_RUN  = 3'b100
    } state_t;

endpackage

FILE: hdl/fbpa_ram.sv
// Free-address stack storage for the fixed block pool allocator.
// One write port and one read port with a registered read; no package needed.
module fbpa_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: controller, level registers and result port.
// Depends on fbpa_pkg and on fbpa_ram for the free-address stack.
//
// The pool keeps a last-in-first-out stack of free block addresses in a
// POOL_DEPTH-entry synchronous memory. A request is taken when start is high
// and busy is low. Its result appears on the result ports with done high for
// exactly one cycle; the receiver cannot stall it, so it must capture the
// result in that cycle. A free request, a no-op request and every request
// that ends in an error finish directly: done is high in the cycle after
// the request is taken. An allocate request passes through the pop state,
// because the stack memory returns the popped address in the cycle after
// its read is issued. An add-run request is first checked, then makes one
// memory write per pushed address; a run of zero blocks finishes directly.
// busy is low again in the cycle in which done is high, so the next request
// can be taken while the result of the previous one is on the ports. Errors
// leave the level, the low-water mark and the stack untouched. The block size
// register may be written only while no request is in progress.
module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Block size register.
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::BSIZE_W-1:0]        cfg_wdata,
    // Request side.
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [ADDR_WIDTH-1:0]               block_address,
    input  logic [fbpa_pkg::COUNT_W-1:0]        block_count,
    // Result side.
    output logic                                done,
    output logic [1:0]                          status,
    output logic [ADDR_WIDTH-1:0]               alloc_address,
    output logic [$clog2(POOL_DEPTH+1)-1:0]     level,
    output logic [$clog2(POOL_DEPTH+1)-1:0]     min_level
);

    localparam int LVL_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W = $clog2(POOL_DEPTH);
    // Width for the room check, wide enough for the level and the count.
    localparam int CMP_W = ((LVL_W > fbpa_pkg::COUNT_W) ? LVL_W : fbpa_pkg::COUNT_W) + 1;

    fbpa_pkg::state_t               state_reg, state_next;
    logic [LVL_W-1:0]               level_reg, level_next;
    logic [LVL_W-1:0]               low_reg, low_next;
    logic [fbpa_pkg::COUNT_W-1:0]   left_reg, left_next;
    logic [ADDR_WIDTH-1:0]          run_addr_reg, run_addr_next;
    logic [fbpa_pkg::BSIZE_W-1:0]   bsize_reg;
    logic                           done_reg, done_next;
    fbpa_pkg::status_t              status_reg, status_next;
    logic [ADDR_WIDTH-1:0]          alloc_reg, alloc_next;
    logic [LVL_W-1:0]               out_level_reg, out_level_next;
    logic [LVL_W-1:0]               out_min_reg, out_min_next;

    logic                           accept;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic [ADDR_WIDTH-1:0]          wr_data;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic [ADDR_WIDTH-1:0]          rd_data;
    logic [LVL_W-1:0]               level_dec;
    logic [LVL_W-1:0]               level_inc;
    logic [CMP_W-1:0]               room;
    logic                           stack_full;

    fbpa_ram #(
        .DEPTH  (POOL_DEPTH),
        .DATA_W (ADDR_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept     = start && (state_reg == fbpa_pkg::S_IDLE);
    assign level_dec  = level_reg - 1'b1;
    assign level_inc  = level_reg + 1'b1;
    assign room       = CMP_W'(POOL_DEPTH) - CMP_W'(level_reg);
    assign stack_full = (level_reg == LVL_W'(POOL_DEPTH));

    // The stack top sits just below the level, so a push writes at the level
    // and a pop reads one below it.
    assign wr_addr = level_reg[IDX_W-1:0];
    assign rd_addr = level_dec[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        low_next       = low_reg;
        left_next      = left_reg;
        run_addr_next  = run_addr_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        alloc_next     = alloc_reg;
        out_level_next = out_level_reg;
        out_min_next   = out_min_reg;
        wr_en          = 1'b0;
        wr_data        = block_address;
        rd_en          = 1'b0;

        case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // Default result: report the state as it stands.
                    status_next    = fbpa_pkg::ST_OK;
                    alloc_next     = '0;
                    out_level_next = level_reg;
                    out_min_next   = low_reg;
                    done_next      = 1'b1;
                    case (req_type)
                        fbpa_pkg::REQ_ALLOC:
                        begin
                            if (level_reg == '0)
                            begin
                                status_next = fbpa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // Issue the read; the result leaves once data is back.
                                rd_en      = 1'b1;
                                done_next  = 1'b0;
                                level_next = level_dec;
                                if (level_dec < low_reg)
                                begin
                                    low_next = level_dec;
                                end
                                state_next = fbpa_pkg::S_POP;
                            end
                        end
                        fbpa_pkg::REQ_FREE:
                        begin
                            if (block_address == '0)
                            begin
                                status_next = fbpa_pkg::ST_NULL;
                            end
                            else if (stack_full)
                            begin
                                status_next = fbpa_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                level_next     = level_inc;
                                out_level_next = level_inc;
                            end
                        end
                        fbpa_pkg::REQ_RUN:
                        begin
                            if (block_address == '0)
                            begin
                                status_next = fbpa_pkg::ST_NULL;
                            end
                            else if (CMP_W'(block_count) > room)
                            begin
                                status_next = fbpa_pkg::ST_FULL;
                            end
                            else if (block_count != '0)
                            begin
                                // The mark rises by the whole run up front; the
                                // run then pushes one address per cycle.
                                done_next     = 1'b0;
                                low_next      = LVL_W'(CMP_W'(low_reg) + CMP_W'(block_count));
                                left_next     = block_count;
                                run_addr_next = block_address;
                                state_next    = fbpa_pkg::S_RUN;
                            end
                        end
                        default:
                        begin
                            // No-op request: the default result stands.
                        end
                    endcase
                end
            end
            fbpa_pkg::S_POP:
            begin
                status_next    = fbpa_pkg::ST_OK;
                alloc_next     = rd_data;
                out_level_next = level_reg;
                out_min_next   = low_reg;
                done_next      = 1'b1;
                state_next     = fbpa_pkg::S_IDLE;
            end
            fbpa_pkg::S_RUN:
            begin
                wr_en         = 1'b1;
                wr_data       = run_addr_reg;
                level_next    = level_inc;
                run_addr_next = run_addr_reg + ADDR_WIDTH'(bsize_reg);
                left_next     = left_reg - 1'b1;
                if (left_reg == fbpa_pkg::COUNT_W'(1))
                begin
                    status_next    = fbpa_pkg::ST_OK;
                    alloc_next     = '0;
                    out_level_next = level_inc;
                    out_min_next   = low_reg;
                    done_next      = 1'b1;
                    state_next     = fbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::S_IDLE;
            level_reg <= '0;
            low_reg   <= '0;
            left_reg  <= '0;
            bsize_reg <= fbpa_pkg::BSIZE_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            low_reg   <= low_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                bsize_reg <= cfg_wdata;
            end
        end
    end

    // Result and run payload registers need no reset.
    always_ff @(posedge clk)
    begin
        run_addr_reg  <= run_addr_next;
        status_reg    <= status_next;
        alloc_reg     <= alloc_next;
        out_level_reg <= out_level_next;
        out_min_reg   <= out_min_next;
    end

    assign busy          = (state_reg != fbpa_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign alloc_address = alloc_reg;
    assign level         = out_level_reg;
    assign min_level     = out_min_reg;

    // The level never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(POOL_DEPTH))
        else $error("free level above pool depth");

    // Outside a run the low-water mark never stands above the level. A run
    // raises the mark before its pushes catch the level up.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != fbpa_pkg::S_RUN |-> low_reg <= level_reg)
        else $error("low-water mark above level");

    // A pop always delivers its result in the cycle after the pop state.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbpa_pkg::S_POP |=> done_reg)
        else $error("allocate result missing after stack read");

    // Each run cycle pushes exactly one address.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbpa_pkg::S_RUN |=> level_reg == LVL_W'($past(level_reg) + 1'b1))
        else $error("run push did not advance level");

    // An error result leaves the level as it was before the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != fbpa_pkg::ST_OK |-> level_reg == $past(level_reg))
        else $error("error request changed the level");

endmodule

FILE: tb/fbpa_result_checker.sv
// Result checker for the fixed block pool allocator testbench.
// Watches the request, result and block size ports, predicts each result and compares.
// Depends on fbpa_pkg.
module fbpa_result_checker #(
    parameter int POOL_DEPTH = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::BSIZE_W-1:0]        cfg_wdata,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [ADDR_WIDTH-1:0]               block_address,
    input  logic [fbpa_pkg::COUNT_W-1:0]        block_count,
    input  logic                                done,
    input  logic [1:0]                          status,
    input  logic [ADDR_WIDTH-1:0]               alloc_address,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]     level,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]     min_level,
    output int                                  fail_count,
    output int                                  pending,
    output logic [$clog2(POOL_DEPTH+1)-1:0]     pool_level
);

    localparam int LEVEL_W = $clog2(POOL_DEPTH + 1);

    typedef struct packed {
        fbpa_pkg::status_t      st;
        logic [ADDR_WIDTH-1:0]  addr;
        logic [LEVEL_W-1:0]     lvl;
        logic [LEVEL_W-1:0]     mark;
    } pool_result_t;

    // Shadow copy of the pool state and of the block size register.
    logic [ADDR_WIDTH-1:0]          free_addrs [POOL_DEPTH];
    int unsigned                    held;
    int unsigned                    low_mark;
    logic [fbpa_pkg::BSIZE_W-1:0]   stride;
    pool_result_t                   pending_results [$];
    int                             failures;

    // Applies one request to the shadow state and returns the result it must produce.
    function automatic pool_result_t serve_request(
        input logic [1:0]                   kind,
        input logic [ADDR_WIDTH-1:0]        addr,
        input logic [fbpa_pkg::COUNT_W-1:0] cnt);
        pool_result_t r;
        logic [ADDR_WIDTH-1:0] next_addr;
        r.st   = fbpa_pkg::ST_OK;
        r.addr = '0;
        case (kind)
            fbpa_pkg::REQ_ALLOC:
            begin
                if (held == 0)
                begin
                    r.st = fbpa_pkg::ST_EMPTY;
                end
                else
                begin
                    held--;
                    r.addr = free_addrs[held];
                    if (held < low_mark) low_mark = held;
                end
            end
            fbpa_pkg::REQ_FREE:
            begin
                if (addr == '0)
                begin
                    r.st = fbpa_pkg::ST_NULL;
                end
                else if (held >= POOL_DEPTH)
                begin
                    r.st = fbpa_pkg::ST_FULL;
                end
                else
                begin
                    free_addrs[held] = addr;
                    held++;
                end
            end
            fbpa_pkg::REQ_RUN:
            begin
                if (addr == '0)
                begin
                    r.st = fbpa_pkg::ST_NULL;
                end
                else if (cnt > POOL_DEPTH - held)
                begin
                    r.st = fbpa_pkg::ST_FULL;
                end
                else
                begin
                    // Run addresses wrap at the address width; a wrapped zero is pushed too.
                    next_addr = addr;
                    for (int i = 0; i < cnt; i++)
                    begin
                        free_addrs[held] = next_addr;
                        held++;
                        next_addr = next_addr + ADDR_WIDTH'(stride);
                    end
                    low_mark += cnt;
                end
            end
            default: ;
        endcase
        r.lvl  = LEVEL_W'(held);
        r.mark = LEVEL_W'(low_mark);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pool_result_t want;
        if (!rst_n)
        begin
            held     = 0;
            low_mark = 0;
            stride   = fbpa_pkg::BSIZE_RESET;
            failures = 0;
            pending_results.delete();
            fail_count <= 0;
            pending    <= 0;
            pool_level <= '0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result: status %0d address %h level %0d mark %0d",
                                 status, alloc_address, level, min_level);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st || alloc_address !== want.addr ||
                        level !== want.lvl || min_level !== want.mark)
                    begin
                        if (failures < 10)
                            $display("mismatch exp/act: st %0d/%0d addr %h/%h lvl %0d/%0d mark %0d/%0d",
                                     want.st, status, want.addr, alloc_address,
                                     want.lvl, level, want.mark, min_level);
                        failures++;
                    end
                end
            end
            if (cfg_we) stride = cfg_wdata;
            if (start && !busy)
                pending_results.push_back(serve_request(req_type, block_address, block_count));
            fail_count <= failures;
            pending    <= pending_results.size();
            pool_level <= LEVEL_W'(held);
        end
    end

endmodule

FILE: tb/fixed_block_pool_allocator_tb.sv
// Testbench top for the fixed block pool allocator: clock, reset, request stimulus and verdict.
// Depends on fbpa_pkg, fixed_block_pool_allocator and fbpa_result_checker.
// Directed corner requests are followed by random segments under several block sizes.
module fixed_block_pool_allocator_tb;

    localparam int POOL_DEPTH    = 256;
    localparam int ADDR_WIDTH    = 32;
    localparam int LEVEL_W       = $clog2(POOL_DEPTH + 1);
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 100;
    // The fourth request code has no name in the package; the block treats it as a no-op.
    localparam logic [1:0] REQ_NOOP = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fbpa_pkg::BSIZE_W-1:0]   cfg_wdata;
    logic                           start;
    logic                           busy;
    logic [1:0]                     req_type;
    logic [ADDR_WIDTH-1:0]          block_address;
    logic [fbpa_pkg::COUNT_W-1:0]   block_count;
    logic                           done;
    logic [1:0]                     status;
    logic [ADDR_WIDTH-1:0]          alloc_address;
    logic [LEVEL_W-1:0]             level;
    logic [LEVEL_W-1:0]             min_level;

    int                             fail_count;
    int                             pending;
    logic [LEVEL_W-1:0]             pool_level;
    // Chance in percent that the request side sits idle in any one cycle.
    int                             idle_pct;
    logic [fbpa_pkg::BSIZE_W-1:0]   bsize;

    fixed_block_pool_allocator #(
        .POOL_DEPTH     (POOL_DEPTH),
        .ADDR_WIDTH     (ADDR_WIDTH)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .block_address  (block_address),
        .block_count    (block_count),
        .done           (done),
        .status         (status),
        .alloc_address  (alloc_address),
        .level          (level),
        .min_level      (min_level)
    );

    // The checker sees the same ports as the block, predicts every result and
    // reports the failure count, the number of results still owed and the
    // predicted pool level, which the stimulus uses to steer its request mix.
    fbpa_result_checker #(
        .POOL_DEPTH     (POOL_DEPTH),
        .ADDR_WIDTH     (ADDR_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .block_address  (block_address),
        .block_count    (block_count),
        .done           (done),
        .status         (status),
        .alloc_address  (alloc_address),
        .level          (level),
        .min_level      (min_level),
        .fail_count     (fail_count),
        .pending        (pending),
        .pool_level     (pool_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is bounded by a cycle count; reaching it means something hung.
    initial
    begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
        $display("[fixed_block_pool_allocator] ERROR");
        $finish;
    end

    // Presents one request and holds it until the block takes it. All signals
    // are updated right after a rising edge, and busy is read right after the
    // edge as well, so the value seen is the one the block sampled. Afterwards
    // each cycle is an idle one with a chance of idle_pct; when none is drawn,
    // start stays high and the next request goes out back to back.
    task automatic issue_request(input logic [1:0] kind, input logic [ADDR_WIDTH-1:0] addr,
                                 input logic [fbpa_pkg::COUNT_W-1:0] cnt);
        start         <= 1'b1;
        req_type      <= kind;
        block_address <= addr;
        block_count   <= cnt;
        @(posedge clk);
        while (busy) @(posedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops issuing and waits until every request has produced its result.
    // The first edge lets the checker count a request taken at the current edge.
    // Then the task idles on so that the block is surely back at rest.
    task automatic settle_pool();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The block size register may only change while no request is in progress.
    task automatic write_block_size(input logic [fbpa_pkg::BSIZE_W-1:0] value);
        settle_pool();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random request. The mix leans toward pushes when the pool runs low and
    // toward allocates when it runs high, so the level keeps moving across its
    // whole range and both the empty and the full errors keep turning up.
    task automatic random_request();
        int                             roll;
        int                             alloc_pct;
        int                             room;
        logic [1:0]                     kind;
        logic [ADDR_WIDTH-1:0]          addr;
        logic [fbpa_pkg::COUNT_W-1:0]   cnt;
        room      = POOL_DEPTH - int'(pool_level);
        alloc_pct = (pool_level < 4) ? 20 : (pool_level > 200) ? 60 : 42;
        roll      = $urandom_range(99);
        if (roll < alloc_pct)
            kind = fbpa_pkg::REQ_ALLOC;
        else if (roll < 96)
            kind = ($urandom_range(2) == 0) ? fbpa_pkg::REQ_RUN : fbpa_pkg::REQ_FREE;
        else
            kind = REQ_NOOP;
        // Mostly arbitrary addresses, with null ones and ones just below the
        // top of the address space, where a run wraps around.
        case ($urandom_range(15))
            0:       addr = '0;
            1:       addr = '1 - ADDR_WIDTH'($urandom_range(1023));
            default: addr = ADDR_WIDTH'($urandom());
        endcase
        // Runs are mostly short to keep the run quick; now and then one is empty,
        // the whole pool, a random size, or exactly the room that is left.
        case ($urandom_range(19))
            0:       cnt = '0;
            1:       cnt = fbpa_pkg::COUNT_W'(POOL_DEPTH);
            2:       cnt = fbpa_pkg::COUNT_W'($urandom_range(POOL_DEPTH));
            3:       cnt = fbpa_pkg::COUNT_W'(room);
            default: cnt = fbpa_pkg::COUNT_W'($urandom_range(1, 8));
        endcase
        issue_request(kind, addr, cnt);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        start         <= 1'b0;
        req_type      <= fbpa_pkg::REQ_ALLOC;
        block_address <= '0;
        block_count   <= '0;
        idle_pct      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the block size at its reset value of four.
        // Allocate from an empty pool, then null addresses on free and add-run.
        issue_request(fbpa_pkg::REQ_ALLOC, '0, '0);
        issue_request(fbpa_pkg::REQ_FREE, '0, '0);
        issue_request(fbpa_pkg::REQ_RUN, '0, 9'd5);
        // An empty run with a valid base is accepted and changes nothing.
        issue_request(fbpa_pkg::REQ_RUN, 32'h0000_0100, '0);
        // The unused request code only reports the current level and mark.
        issue_request(REQ_NOOP, '1, 9'd256);
        // Largest address in and out again.
        issue_request(fbpa_pkg::REQ_FREE, '1, '0);
        issue_request(fbpa_pkg::REQ_ALLOC, '0, '0);
        // A run of the whole pool whose addresses wrap through zero.
        issue_request(fbpa_pkg::REQ_RUN, 32'hFFFF_FFF8, 9'd256);
        // Pushes into the full pool must be refused, a run as a whole.
        issue_request(fbpa_pkg::REQ_FREE, 32'h0000_1234, '0);
        issue_request(fbpa_pkg::REQ_RUN, 32'h0000_0010, 9'd1);
        repeat (3) issue_request(fbpa_pkg::REQ_ALLOC, '0, '0);
        // A run one larger than the room left, then one that fits exactly.
        issue_request(fbpa_pkg::REQ_RUN, 32'h0000_2000, 9'd4);
        issue_request(fbpa_pkg::REQ_RUN, 32'h0000_3000, 9'd3);
        // The mark drops on an allocate and stays put on a free.
        issue_request(fbpa_pkg::REQ_ALLOC, 32'h8000_0001, 9'd256);
        issue_request(fbpa_pkg::REQ_FREE, 32'hAAAA_5555, '0);
        issue_request(REQ_NOOP, '0, '0);
        issue_request(fbpa_pkg::REQ_RUN, 32'h0000_0040, 9'd255);

        // Random segments. Each starts with a new block size, covering a stride of
        // 65536, the reset value, the all-ones register value, zero, a stride that
        // is not a multiple of four, and a random one.
        // The request side idles sometimes, then mostly, then never.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       bsize = 17'd65536;
                1:       bsize = fbpa_pkg::BSIZE_RESET;
                2:       bsize = 17'h1FFFF;
                3:       bsize = 17'd0;
                4:       bsize = 17'd3;
                default: bsize = fbpa_pkg::BSIZE_W'($urandom_range(1, 16384) * 4);
            endcase
            write_block_size(bsize);
            idle_pct = (seg < 2) ? 29 : (seg < 4) ? 69 : 0;
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                // Once in mid-segment the request side holds off until the
                // block has answered every request it has taken.
                if (seg == 2 && k == SEGMENT_ITEMS / 2) settle_pool();
                random_request();
            end
        end

        settle_pool();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[fixed_block_pool_allocator] OK");
        else
            $display("[fixed_block_pool_allocator] ERROR");
        $finish;
    end

endmodule
